FILE: src/prl_pkg.sv
// Shared types and codes for the positional record list.
`timescale 1ns / 1ps

package prl_pkg;

  localparam int unsigned DepthDefault = 16;

  // Command codes carried in the low bits of the input data
  typedef enum logic [2:0] {
    CMD_ADD_FRONT    = 3'd0,
    CMD_ADD_BACK     = 3'd1,
    CMD_INSERT_AT    = 3'd2,
    CMD_REMOVE_FRONT = 3'd3,
    CMD_REMOVE_BACK  = 3'd4,
    CMD_REMOVE_AT    = 3'd5,
    CMD_READ_AT      = 3'd6
  } cmd_e;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // One date record, day in the lowest bits
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } rec_t;

  // What every cell does on a given cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_TAKE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

endpackage

FILE: src/positional_record_list.sv
// Top level of the positional record list.
`timescale 1ns / 1ps

// Bounded ordered list of DEPTH date records held in a chain of cells. Each
// transfer on the slave side carries one command and yields exactly one result
// on the master side, registered in the cycle after the input transfer. The whole
// chain shifts or loads in that same cycle, so a new command is taken every
// cycle while the result register is empty or being emptied; a stalled result
// holds the input back. Records are stored without reset; only entries below
// the count are ever returned.
module positional_record_list import prl_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], day[7:3], month[11:8], year[25:12], position[30:26], zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], entry_count[6:2], out_day[11:7], out_month[15:12],
  // out_year[29:16], zero
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = ((CntW > 5) ? CntW : 5) + 1;

  logic [2:0]      in_cmd;
  rec_t            in_rec;
  logic [4:0]      in_pos;
  logic            accept;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  rec_t            got_q, got_d;

  logic [CmpW-1:0] pos_w, cnt_w;
  logic            full, empty;
  cell_op_e        op;
  logic [IdxW-1:0] idx;
  logic            rd;
  cell_ctrl_t      ctrl;
  rec_t            got_any;

  rec_t cell_rec [DEPTH];
  rec_t cell_sel [DEPTH];

  assign in_cmd = s_axis_tdata[2:0];
  assign in_rec = rec_t'{year: s_axis_tdata[25:12], month: s_axis_tdata[11:8],
                         day: s_axis_tdata[7:3]};
  assign in_pos = s_axis_tdata[30:26];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_w = CmpW'(in_pos);
  assign cnt_w = CmpW'(count_q);
  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // Command decode against the current count
  always_comb begin
    status_d = ST_OK;
    op       = CELL_HOLD;
    idx      = '0;
    rd       = 1'b0;
    case (in_cmd)
      CMD_ADD_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op = CELL_INS;
        end
      end
      CMD_ADD_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op  = CELL_INS;
          idx = IdxW'(count_q);
        end
      end
      CMD_INSERT_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_w < CmpW'(2) || pos_w > cnt_w + CmpW'(1)) begin
          status_d = ST_BADPOS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          op  = CELL_INS;
          idx = IdxW'(pos_w - CmpW'(1));
        end
      end
      CMD_REMOVE_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          op = CELL_TAKE;
        end
      end
      CMD_REMOVE_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          op  = CELL_TAKE;
          idx = IdxW'(cnt_w - CmpW'(1));
        end
      end
      CMD_REMOVE_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_w < CmpW'(2) || pos_w > cnt_w) begin
          status_d = ST_BADPOS;
        end else begin
          op  = CELL_TAKE;
          idx = IdxW'(pos_w - CmpW'(1));
        end
      end
      CMD_READ_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_w < CmpW'(1) || pos_w > cnt_w) begin
          status_d = ST_BADPOS;
        end else begin
          rd  = 1'b1;
          idx = IdxW'(pos_w - CmpW'(1));
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign ctrl.op  = accept ? op : CELL_HOLD;
  assign ctrl.rec = in_rec;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_rec[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_rec[i+1];
    end

    prl_cell #(
      .DEPTH   (DEPTH),
      .CELL_IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .idx_i  (idx),
      .left_i (left),
      .right_i(right),
      .rec_o  (cell_rec[i]),
      .sel_o  (cell_sel[i])
    );
  end

  // one-hot selection: only the addressed cell drives a non-zero value
  always_comb begin
    got_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      got_any = got_any | cell_sel[i];
    end
  end

  assign got_d = (op == CELL_TAKE || rd) ? got_any : '0;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (op == CELL_INS) begin
        count_d = count_q + CntW'(1);
      end else if (op == CELL_TAKE) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      got_q    <= got_d;
    end
  end

  logic [CntW-1:0] count_out_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_out_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, got_q.year, got_q.month, got_q.day,
                          5'(count_out_q), status_q};

endmodule

FILE: src/prl_cell.sv
// One storage cell of the record chain.
`timescale 1ns / 1ps

module prl_cell import prl_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned IdxW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [IdxW-1:0] idx_i,
  input  rec_t            left_i,
  input  rec_t            right_i,
  output rec_t            rec_o,
  output rec_t            sel_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.op)
      CELL_INS: begin
        // cells behind the insertion point move one place back
        if (MyIdx == idx_i) begin
          rec_d = ctrl_i.rec;
        end else if (MyIdx > idx_i) begin
          rec_d = left_i;
        end
      end
      CELL_TAKE: begin
        if (MyIdx >= idx_i) begin
          rec_d = right_i;
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;
  assign sel_o = (MyIdx == idx_i) ? rec_q : '0;

endmodule

FILE: src/prl_checker.sv
// Port-level checks for the positional record list, bound to the top level.
`timescale 1ns / 1ps

module prl_checker import prl_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [1:0] status;
  logic [4:0] cnt;
  logic [8:0] cnt_w;

  assign status = m_axis_tdata[1:0];
  assign cnt    = m_axis_tdata[6:2];
  assign cnt_w  = 9'(cnt);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // failed commands return no record
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ST_OK |-> m_axis_tdata[29:7] == '0)
    else $error("record fields set on error status");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_EMPTY |-> cnt == '0)
    else $error("empty status with non-zero count");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_FULL |-> cnt == 5'(DEPTH))
    else $error("full status with count below depth");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_w <= 9'(DEPTH))
    else $error("count beyond depth");

endmodule

bind positional_record_list prl_checker #(.DEPTH(DEPTH)) u_prl_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking bench for the positional record list: random and directed commands.
`timescale 1ns / 1ps

module tb_top;
  import prl_pkg::*;

  localparam int Depth = DepthDefault;
  localparam int HoldCycles = 200;
  localparam int StallLimit = 4000;
  // Command code with no operation behind it
  localparam logic [2:0] CmdUnused = 3'd7;

  typedef struct packed {
    logic [4:0] pos;
    rec_t       rec;
    logic [2:0] cmd;
  } list_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [4:0] count;
    rec_t       rec;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // command[2:0], day[7:3], month[11:8], year[25:12], position[30:26], zero
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], entry_count[6:2], out_day[11:7], out_month[15:12],
  // out_year[29:16], zero
  logic [31:0] m_axis_tdata;

  rec_t         list_image[$];
  list_result_t expected_results[$];
  int           errors = 0;
  int           snd_idle = 0;
  int           rcv_idle = 0;
  int           hold_reqs = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  bit           fill_phase = 1'b1;

  positional_record_list dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Applies one command to the shadow list and returns the result it should give
  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    int n;
    int p;
    n = list_image.size();
    p = c.pos;
    r.status = ST_OK;
    r.rec = '0;
    case (c.cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        if (n >= Depth) r.status = ST_FULL;
        else if (c.cmd == CMD_ADD_FRONT) list_image.push_front(c.rec);
        else list_image.push_back(c.rec);
      end
      CMD_INSERT_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 2 || p > n + 1) r.status = ST_BADPOS;
        else if (n >= Depth) r.status = ST_FULL;
        else list_image.insert(p - 1, c.rec);
      end
      CMD_REMOVE_FRONT: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.rec = list_image.pop_front();
      end
      CMD_REMOVE_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.rec = list_image.pop_back();
      end
      CMD_REMOVE_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 2 || p > n) r.status = ST_BADPOS;
        else begin
          r.rec = list_image[p - 1];
          list_image.delete(p - 1);
        end
      end
      CMD_READ_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > n) r.status = ST_BADPOS;
        else r.rec = list_image[p - 1];
      end
      default: ;
    endcase
    r.count = 5'(list_image.size());
    return r;
  endfunction

  function automatic list_cmd_t mk(logic [2:0] cmd, logic [4:0] day, logic [3:0] month,
                                   logic [13:0] year, logic [4:0] pos);
    list_cmd_t c;
    c.cmd = cmd;
    c.rec.day = day;
    c.rec.month = month;
    c.rec.year = year;
    c.pos = pos;
    return c;
  endfunction

  // Alternates between filling and draining runs so both full and empty lists occur
  function automatic list_cmd_t random_cmd();
    list_cmd_t c;
    int n;
    int roll;
    n = list_image.size();
    if (n == 0) fill_phase = 1'b1;
    else if (n >= Depth && $urandom_range(2) == 0) fill_phase = 1'b0;
    else if ($urandom_range(49) == 0) fill_phase = !fill_phase;
    roll = $urandom_range(99);
    if (roll < 2) c.cmd = CmdUnused;
    else if (fill_phase) begin
      if (roll < 30) c.cmd = CMD_ADD_FRONT;
      else if (roll < 55) c.cmd = CMD_ADD_BACK;
      else if (roll < 75) c.cmd = CMD_INSERT_AT;
      else if (roll < 82) c.cmd = CMD_REMOVE_FRONT;
      else if (roll < 88) c.cmd = CMD_REMOVE_BACK;
      else if (roll < 93) c.cmd = CMD_REMOVE_AT;
      else c.cmd = CMD_READ_AT;
    end else begin
      if (roll < 8) c.cmd = CMD_ADD_FRONT;
      else if (roll < 15) c.cmd = CMD_ADD_BACK;
      else if (roll < 22) c.cmd = CMD_INSERT_AT;
      else if (roll < 40) c.cmd = CMD_REMOVE_FRONT;
      else if (roll < 58) c.cmd = CMD_REMOVE_BACK;
      else if (roll < 78) c.cmd = CMD_REMOVE_AT;
      else c.cmd = CMD_READ_AT;
    end
    c.rec.day = 5'($urandom_range(31));
    c.rec.month = 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1));
    c.rec.year = 14'(($urandom_range(6) == 0) ? $urandom_range(16383) : $urandom_range(9999));
    // mostly in or just past the live range, otherwise anything the field holds
    if ($urandom_range(3) != 0) c.pos = 5'($urandom_range((n + 1 > 1) ? n + 1 : 1, 1));
    else c.pos = 5'($urandom_range(31));
    return c;
  endfunction

  task automatic send_cmd(input list_cmd_t c);
    int gap;
    if ($urandom_range(99) < snd_idle) begin
      gap = $urandom_range(4, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Input transfers feed the shadow list; output transfers are checked in order
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_list_cmd(list_cmd_t'(s_axis_tdata[30:0])));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
          check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[6:2]));
          check_field("out_day", 32'(want.rec.day), 32'(m_axis_tdata[11:7]));
          check_field("out_month", 32'(want.rec.month), 32'(m_axis_tdata[15:12]));
          check_field("out_year", 32'(want.rec.year), 32'(m_axis_tdata[29:16]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL positional_record_list");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    snd_idle = 20;
    rcv_idle = 20;
    // empty list on every command that needs an entry, then an unused code
    send_cmd(mk(CMD_READ_AT, 5'd1, 4'd1, 14'd1, 5'd1));
    send_cmd(mk(CMD_REMOVE_FRONT, 5'd0, 4'd0, 14'd0, 5'd0));
    send_cmd(mk(CMD_REMOVE_BACK, 5'd0, 4'd0, 14'd0, 5'd0));
    send_cmd(mk(CMD_REMOVE_AT, 5'd0, 4'd0, 14'd0, 5'd2));
    send_cmd(mk(CMD_INSERT_AT, 5'd9, 4'd3, 14'd2000, 5'd2));
    send_cmd(mk(CmdUnused, 5'd31, 4'd15, 14'd16383, 5'd31));
    // adds create the list; out-of-range fields are kept as given
    send_cmd(mk(CMD_ADD_FRONT, 5'd31, 4'd15, 14'd16383, 5'd31));
    send_cmd(mk(CMD_ADD_BACK, 5'd0, 4'd0, 14'd0, 5'd0));
    send_cmd(mk(CMD_INSERT_AT, 5'd1, 4'd1, 14'd1, 5'd1));
    send_cmd(mk(CMD_INSERT_AT, 5'd1, 4'd12, 14'd9999, 5'd3));
    send_cmd(mk(CMD_INSERT_AT, 5'd15, 4'd6, 14'd1984, 5'd2));
    send_cmd(mk(CMD_INSERT_AT, 5'd15, 4'd6, 14'd1984, 5'd31));
    send_cmd(mk(CMD_READ_AT, 5'd0, 4'd0, 14'd0, 5'd0));
    send_cmd(mk(CMD_READ_AT, 5'd0, 4'd0, 14'd0, 5'd1));
    send_cmd(mk(CMD_READ_AT, 5'd0, 4'd0, 14'd0, 5'd4));
    send_cmd(mk(CMD_READ_AT, 5'd0, 4'd0, 14'd0, 5'd31));
    send_cmd(mk(CMD_REMOVE_AT, 5'd0, 4'd0, 14'd0, 5'd1));
    send_cmd(mk(CMD_REMOVE_AT, 5'd0, 4'd0, 14'd0, 5'd4));
    send_cmd(mk(CMD_REMOVE_AT, 5'd0, 4'd0, 14'd0, 5'd2));
    send_cmd(mk(CMD_REMOVE_FRONT, 5'd0, 4'd0, 14'd0, 5'd0));
    send_cmd(mk(CMD_REMOVE_AT, 5'd0, 4'd0, 14'd0, 5'd2));
    // removing the only entry empties the list
    send_cmd(mk(CMD_REMOVE_BACK, 5'd0, 4'd0, 14'd0, 5'd0));
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    repeat (count) send_cmd(random_cmd());
  endtask

  // Receiver stalls for a long stretch while commands keep coming
  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    hold_reqs++;
    repeat (40) send_cmd(random_cmd());
  endtask

  // Sender waits for every outstanding result before carrying on
  task automatic test_sender_pause();
    snd_idle = 0;
    rcv_idle = 30;
    repeat (20) send_cmd(random_cmd());
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (20) send_cmd(random_cmd());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(380, 13, 67);
    test_random(380, 67, 13);
    test_random(330, 0, 0);
    test_backpressure();
    test_sender_pause();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
    if (errors == 0) $display("PASS positional_record_list");
    else $display("FAIL positional_record_list");
    $finish;
  end

endmodule

FILE: positional_record_list.f
src/prl_pkg.sv
src/prl_cell.sv
src/positional_record_list.sv
src/prl_checker.sv
tb/sv/tb_top.sv
